// ===== design/wwvb_pkg.sv =====
// Package: field widths, frame layout, symbol durations and divide constants for the WWVB encoder.
package wwvb_pkg;

    // Input field widths
    localparam int MinW  = 6;
    localparam int HourW = 5;
    localparam int YdayW = 9;
    localparam int YearW = 14;

    // Output field widths
    localparam int SecW = 6;
    localparam int MsW  = 10;

    // Frame and digit geometry
    localparam int FrameW = 60;
    localparam int DigitW = 4;
    localparam int RemW   = 7;

    // Bit positions of the least significant digit of each field
    localparam int MinPos   = 59 - 8;
    localparam int HourPos  = 59 - 18;
    localparam int YdayPos  = 59 - 33;
    localparam int YearPos  = 59 - 53;
    localparam int LeapPos  = 59 - 55;
    localparam int DstNPos  = 59 - 57;
    localparam int DstTPos  = 59 - 58;

    // Symbol durations in ms
    localparam logic [MsW-1:0] MarkerMs = 10'd800;
    localparam logic [MsW-1:0] OneMs    = 10'd500;
    localparam logic [MsW-1:0] ZeroMs   = 10'd200;

    localparam logic [SecW-1:0] LastSec = 6'd59;

    // Reciprocal constants for divide by 10 and by 100
    localparam int Rcp10     = 205;
    localparam int Rcp10Sh   = 11;
    localparam int Rcp100Y   = 41;
    localparam int Rcp100YSh = 12;
    localparam int Rcp100L   = 5243;
    localparam int Rcp100LSh = 19;

endpackage

// ===== design/wwvb_time_code_encoder.sv =====
// When idle, an accepted word is registered in stages 1 to 4 and then in the symbol shifter, which gives second 0.
// Each time word yields 60 symbol words, one per cycle while m_axis_tready is high; later words wait in the pipeline.
// The next minute's frame waits at the end of the 4-stage pipeline and is loaded into
// the symbol shifter at the edge that accepts the second-59 word, so symbols run gap-free.
// Reset (i_rst_n low, synchronous) clears all valid bits and the symbol counters.
module wwvb_time_code_encoder import wwvb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] minute, [10:6] hour, [19:11] day_of_year, [33:20] full_year,
    // [34] dst_today, [35] dst_tomorrow, [39:36] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] second_index, [15:6] low_duration_ms
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // Input field unpack
    logic [MinW-1:0]  w_min;
    logic [HourW-1:0] w_hour;
    logic [YdayW-1:0] w_yday;
    logic [YearW-1:0] w_year;
    assign w_min  = s_axis_tdata[5:0];
    assign w_hour = s_axis_tdata[10:6];
    assign w_yday = s_axis_tdata[19:11];
    assign w_year = s_axis_tdata[33:20];

    // Stage enables (ready chain)
    logic en1, en2, en3, en4, ser_adv, ser_take;
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1: split minute and hour tens, divide day and year by 100
    logic [13:0]       w_min_p;
    logic [12:0]       w_hour_p;
    logic [14:0]       w_yday_p;
    logic [26:0]       w_year_p;
    logic [DigitW-1:0] r_s1_min_t, r_s1_hour_t;
    logic [MinW-1:0]   r_s1_min;
    logic [HourW-1:0]  r_s1_hour;
    logic [YdayW-1:0]  r_s1_yday;
    logic [YearW-1:0]  r_s1_year;
    logic [2:0]        r_s1_yday_q;
    logic [7:0]        r_s1_year_q;
    logic              r_s1_dst_t, r_s1_dst_n;

    assign w_min_p  = 14'(w_min) * 14'(Rcp10);
    assign w_hour_p = 13'(w_hour) * 13'(Rcp10);
    assign w_yday_p = 15'(w_yday) * 15'(Rcp100Y);
    assign w_year_p = 27'(w_year) * 27'(Rcp100L);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_min_t  <= DigitW'(w_min_p >> Rcp10Sh);
            r_s1_hour_t <= DigitW'(w_hour_p >> Rcp10Sh);
            r_s1_yday_q <= 3'(w_yday_p >> Rcp100YSh);
            r_s1_year_q <= 8'(w_year_p >> Rcp100LSh);
            r_s1_min    <= w_min;
            r_s1_hour   <= w_hour;
            r_s1_yday   <= w_yday;
            r_s1_year   <= w_year;
            r_s1_dst_t  <= s_axis_tdata[34];
            r_s1_dst_n  <= s_axis_tdata[35];
        end
    end

    // Stage 2: remainders, minute and hour ones, leap bit
    logic [DigitW-1:0] r_s2_min_t, r_s2_min_o, r_s2_hour_t, r_s2_hour_o, r_s2_yday_h;
    logic [RemW-1:0]   r_s2_yday_r, r_s2_year_r;
    logic              r_s2_leap, r_s2_dst_t, r_s2_dst_n;
    logic [RemW-1:0]   w_year_r;

    assign w_year_r = RemW'(r_s1_year - YearW'(r_s1_year_q) * YearW'(100));

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_min_t  <= r_s1_min_t;
            r_s2_min_o  <= DigitW'(r_s1_min - MinW'(r_s1_min_t) * MinW'(10));
            r_s2_hour_t <= r_s1_hour_t;
            r_s2_hour_o <= DigitW'(r_s1_hour - HourW'(r_s1_hour_t) * HourW'(10));
            r_s2_yday_h <= DigitW'(r_s1_yday_q);
            r_s2_yday_r <= RemW'(r_s1_yday - YdayW'(r_s1_yday_q) * YdayW'(100));
            r_s2_year_r <= w_year_r;
            // divisible by 400 when year mod 100 is zero and year/100 is a multiple of 4
            r_s2_leap   <= (r_s1_year[1:0] == 2'd0)
                           && ((w_year_r != '0) || (r_s1_year_q[1:0] == 2'd0));
            r_s2_dst_t  <= r_s1_dst_t;
            r_s2_dst_n  <= r_s1_dst_n;
        end
    end

    // Stage 3: tens of day remainder and two-digit year
    logic [14:0]       w_yday_tp, w_year_tp;
    logic [DigitW-1:0] r_s3_min_t, r_s3_min_o, r_s3_hour_t, r_s3_hour_o, r_s3_yday_h;
    logic [DigitW-1:0] r_s3_yday_t, r_s3_year_t;
    logic [RemW-1:0]   r_s3_yday_r, r_s3_year_r;
    logic              r_s3_leap, r_s3_dst_t, r_s3_dst_n;

    assign w_yday_tp = 15'(r_s2_yday_r) * 15'(Rcp10);
    assign w_year_tp = 15'(r_s2_year_r) * 15'(Rcp10);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_min_t  <= r_s2_min_t;
            r_s3_min_o  <= r_s2_min_o;
            r_s3_hour_t <= r_s2_hour_t;
            r_s3_hour_o <= r_s2_hour_o;
            r_s3_yday_h <= r_s2_yday_h;
            r_s3_yday_t <= DigitW'(w_yday_tp >> Rcp10Sh);
            r_s3_year_t <= DigitW'(w_year_tp >> Rcp10Sh);
            r_s3_yday_r <= r_s2_yday_r;
            r_s3_year_r <= r_s2_year_r;
            r_s3_leap   <= r_s2_leap;
            r_s3_dst_t  <= r_s2_dst_t;
            r_s3_dst_n  <= r_s2_dst_n;
        end
    end

    // Stage 4: ones digits and frame assembly
    logic [DigitW-1:0] w_yday_o, w_year_o;
    logic [FrameW-1:0] w_frame, r_s4_frame;

    assign w_yday_o = DigitW'(r_s3_yday_r - RemW'(r_s3_yday_t) * RemW'(10));
    assign w_year_o = DigitW'(r_s3_year_r - RemW'(r_s3_year_t) * RemW'(10));

    always_comb begin
        w_frame = '0;
        w_frame[MinPos +: 4]       = r_s3_min_o;
        w_frame[MinPos + 5 +: 4]   = r_s3_min_t;
        w_frame[HourPos +: 4]      = r_s3_hour_o;
        w_frame[HourPos + 5 +: 4]  = r_s3_hour_t;
        w_frame[YdayPos +: 4]      = w_yday_o;
        w_frame[YdayPos + 5 +: 4]  = r_s3_yday_t;
        w_frame[YdayPos + 10 +: 4] = r_s3_yday_h;
        w_frame[YearPos +: 4]      = w_year_o;
        w_frame[YearPos + 5 +: 4]  = r_s3_year_t;
        w_frame[LeapPos]           = r_s3_leap;
        w_frame[DstNPos]           = r_s3_dst_n;
        w_frame[DstTPos]           = r_s3_dst_t;
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_frame <= w_frame;
        end
    end

    // Stage 5: symbol shifter and output register
    logic              r_o_valid, r_last;
    logic [SecW-1:0]   r_cnt;
    logic [3:0]        r_unit;
    logic [MsW-1:0]    r_ms;
    logic [FrameW-1:0] r_sh;

    assign ser_adv  = !r_o_valid || m_axis_tready;
    assign ser_take = ser_adv && (!r_o_valid || r_last);

    assign en4 = !r_v4 || ser_take;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    // Advance valid bits through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Load a new frame after second 59 or while the output is empty, else step to the next second
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_unit    <= '0;
            r_last    <= 1'b0;
        end else if (ser_take) begin
            r_o_valid <= r_v4;
            r_cnt     <= '0;
            r_unit    <= '0;
            r_last    <= 1'b0;
        end else if (ser_adv) begin
            r_cnt     <= r_cnt + SecW'(1);
            r_unit    <= (r_unit == 4'd9) ? 4'd0 : r_unit + 4'd1;
            r_last    <= (r_cnt == LastSec - SecW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_take) begin
            r_sh <= r_s4_frame;
            r_ms <= MarkerMs;
        end else if (ser_adv) begin
            r_sh <= {r_sh[FrameW-2:0], 1'b0};
            r_ms <= (r_unit == 4'd8) ? MarkerMs : (r_sh[FrameW-2] ? OneMs : ZeroMs);
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_ms, r_cnt};
    assign m_axis_tlast  = r_last;

`ifndef SYNTH
    // Seconds count up by one within a frame
    a_sec_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && m_axis_tready && !r_last |=> r_o_valid && (r_cnt == $past(r_cnt) + 6'd1))
        else $error("second index did not advance by one");

    // Last flag marks second 59 only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_last == (r_cnt == LastSec)))
        else $error("last flag out of step with second index");

    // Second zero and seconds ending in nine are markers
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_cnt == '0 || r_unit == 4'd9) |-> r_ms == MarkerMs)
        else $error("missing marker symbol");

    // A full pipeline with a stalled output refuses input
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && r_o_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline full");
`endif

endmodule

// ===== tb/tb_wwvb_time_code_encoder.sv =====
// Testbench for the WWVB time code encoder: minute words in, 60 checked symbol words out.
`timescale 1ns / 100ps

module tb_wwvb_time_code_encoder;
    import wwvb_pkg::*;

    localparam int HoldCycles = 500;
    localparam int IdleLimit  = 4000;
    localparam int MaxReports = 40;

    typedef struct {
        logic [MinW-1:0]  minute;
        logic [HourW-1:0] hour;
        logic [YdayW-1:0] yday;
        logic [YearW-1:0] year;
        logic             dst_today;
        logic             dst_tomorrow;
    } t_minute_word;

    typedef struct {
        logic [SecW-1:0] second;
        logic [MsW-1:0]  ms;
        logic            last;
    } t_symbol_word;

    // Build each minute's frame and hold the 60 symbol words it must produce
    class t_symbol_scoreboard;
        t_symbol_word symbol_q[$];
        int           errors;
        int           reports;

        function new();
            errors  = 0;
            reports = 0;
        endfunction

        function logic [63:0] padded_digits(int unsigned v);
            logic [63:0] r;
            r = 64'((v / 100) % 10) << 10;
            r = r | (64'((v / 10) % 10) << 5) | 64'(v % 10);
            return r;
        endfunction

        function void note_minute(t_minute_word w);
            logic [63:0]       f;
            logic [FrameW-1:0] frame;
            int unsigned       y;
            logic              leap;
            t_symbol_word      sym;
            y    = w.year;
            leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
            f = padded_digits(w.minute) << MinPos;
            f = f | (padded_digits(w.hour) << HourPos);
            f = f | (padded_digits(w.yday) << YdayPos);
            f = f | (padded_digits(y % 100) << YearPos);
            f = f | (64'(leap) << LeapPos);
            f = f | (64'(w.dst_tomorrow) << DstNPos);
            f = f | (64'(w.dst_today) << DstTPos);
            frame = f[FrameW-1:0];
            for (int s = 0; s < 60; s++) begin
                sym.second = SecW'(s);
                if (s == 0 || s % 10 == 9)
                    sym.ms = MarkerMs;
                else
                    sym.ms = frame[59 - s] ? OneMs : ZeroMs;
                sym.last = (s == 59);
                symbol_q.push_back(sym);
            end
        endfunction

        function void report(string what, int exp_v, int act_v);
            errors++;
            if (reports < MaxReports) begin
                reports++;
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
            end
        endfunction

        function void check_symbol(logic [15:0] data, logic last);
            t_symbol_word exp_sym;
            if (symbol_q.size() == 0) begin
                report("unexpected symbol word, second", -1, data[SecW-1:0]);
                return;
            end
            exp_sym = symbol_q.pop_front();
            if (data[SecW-1:0] !== exp_sym.second)
                report("second_index", exp_sym.second, data[SecW-1:0]);
            if (data[SecW+MsW-1:SecW] !== exp_sym.ms)
                report("low_duration_ms", exp_sym.ms, data[SecW+MsW-1:SecW]);
            if (last !== exp_sym.last)
                report("tlast", exp_sym.last, last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [5:0] minute, [10:6] hour, [19:11] day_of_year, [33:20] full_year,
    // [34] dst_today, [35] dst_tomorrow, [39:36] zero
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [5:0] second_index, [15:6] low_duration_ms
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    int unsigned rx_cycle = 0;
    int          idle_cycles = 0;

    t_symbol_scoreboard sb = new();

    wwvb_time_code_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: one long hold-off on request, otherwise a rotating stall pattern
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HoldCycles;
            hold_done     <= 1'b1;
        end else begin
            case (rx_cycle[9:8])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= (rx_cycle % 7 != 3);
                default: m_axis_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Note accepted minute words, check accepted symbol words, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                t_minute_word w;
                w.minute       = s_axis_tdata[5:0];
                w.hour         = s_axis_tdata[10:6];
                w.yday         = s_axis_tdata[19:11];
                w.year         = s_axis_tdata[33:20];
                w.dst_today    = s_axis_tdata[34];
                w.dst_tomorrow = s_axis_tdata[35];
                sb.note_minute(w);
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_symbol(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic t_minute_word make_word(int mi, int hr, int yd, int yr, int dt, int dn);
        t_minute_word w;
        w.minute       = MinW'(mi);
        w.hour         = HourW'(hr);
        w.yday         = YdayW'(yd);
        w.year         = YearW'(yr);
        w.dst_today    = dt[0];
        w.dst_tomorrow = dn[0];
        return w;
    endfunction

    // Mostly legal times, some century years, some raw full-width fields
    function automatic t_minute_word random_word();
        t_minute_word w;
        int           mode;
        mode = $urandom_range(0, 9);
        if (mode < 8) begin
            w = make_word($urandom_range(0, 59), $urandom_range(0, 23), $urandom_range(1, 366),
                          $urandom_range(0, 9999), $urandom_range(0, 1), $urandom_range(0, 1));
            if (mode == 0)
                w.year = YearW'($urandom_range(0, 99) * 100);
        end else begin
            w.minute       = MinW'($urandom);
            w.hour         = HourW'($urandom);
            w.yday         = YdayW'($urandom);
            w.year         = YearW'($urandom);
            w.dst_today    = 1'($urandom);
            w.dst_tomorrow = 1'($urandom);
        end
        return w;
    endfunction

    // Offer one minute word and hold it until accepted
    task automatic send_minute(t_minute_word w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, w.dst_tomorrow, w.dst_today, w.year, w.yday, w.hour, w.minute};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Send words in bursts of random length, mostly with random gaps between them
    task automatic send_bursts(ref t_minute_word words[$]);
        int burst;
        while (words.size() != 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && words.size() != 0) begin
                send_minute(words.pop_front());
                burst--;
            end
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 80)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_symbols();
        while (sb.symbol_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_minute_word words[$];
        int           waited;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: field extremes, leap rule corners, DST combinations, odd digits
        words.push_back(make_word(0, 0, 1, 2000, 0, 0));
        words.push_back(make_word(59, 23, 366, 9999, 1, 1));
        words.push_back(make_word(0, 0, 0, 0, 0, 0));
        words.push_back(make_word(63, 31, 511, 16383, 1, 1));
        words.push_back(make_word(30, 12, 180, 1900, 0, 1));
        words.push_back(make_word(15, 6, 60, 2024, 1, 0));
        words.push_back(make_word(45, 18, 400, 2100, 1, 1));
        words.push_back(make_word(1, 1, 399, 2400, 0, 0));
        words.push_back(make_word(9, 9, 99, 2023, 0, 1));
        words.push_back(make_word(10, 10, 100, 1999, 1, 0));
        words.push_back(make_word(58, 22, 365, 9996, 0, 0));
        words.push_back(make_word(7, 3, 250, 8192, 1, 1));
        words.push_back(make_word(59, 0, 1, 1, 0, 0));
        words.push_back(make_word(0, 23, 366, 9900, 1, 1));
        words.push_back(make_word(40, 20, 505, 12345, 0, 1));
        words.push_back(make_word(55, 19, 222, 1600, 1, 0));
        send_bursts(words);

        // Pause until every symbol of the directed minutes is out
        drain_symbols();

        // Random part one, with a long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 220; i++) words.push_back(random_word());
        hold_req <= 1'b1;
        send_bursts(words);

        drain_symbols();

        for (int i = 0; i < 224; i++) words.push_back(random_word());
        send_bursts(words);

        drain_symbols();
        waited = 0;
        while (waited < 20) begin
            @(posedge i_clk);
            waited++;
        end

        if (sb.errors == 0 && sb.symbol_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== wwvb_time_code_encoder.f =====
design/wwvb_pkg.sv
design/wwvb_time_code_encoder.sv
tb/tb_wwvb_time_code_encoder.sv
